// ===== rtl/cwpt_pkg.sv =====
// Shared codes and types for the cell width prefix table.
package cwpt_pkg;

   // Operation codes carried in the func field
   localparam logic [2:0] FUNC_INSERT = 3'd0;
   localparam logic [2:0] FUNC_ERASE  = 3'd1;
   localparam logic [2:0] FUNC_SET    = 3'd2;
   localparam logic [2:0] FUNC_LOCATE = 3'd3;
   localparam logic [2:0] FUNC_RANGE  = 3'd4;
   localparam logic [2:0] FUNC_CLEAR  = 3'd5;

   // Result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_IDX  = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_PAST_END = 2'd3;

   // Fixed field widths of the item channels
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 96;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } cwpt_state_type;

endpackage

// ===== rtl/cwpt_width_ram.sv =====
// Single write, single registered read port memory holding the cell widths.
module cwpt_width_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data in the cycle after the address
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/cell_width_prefix_table_top.sv =====
// Top level of the cell width prefix table: sequencer, shared adder and width memory.
//
//  channel | direction | ports       | contents
//  req     | in        | req_t*      | one operation item
//  rsp     | out       | rsp_t*      | one result item for every operation item
//
// One item at a time. Insert walks count-index cells, erase count-index, locate count,
// range index+1, set one; each walk is paced by the single read port of the width
// memory and one adder. Clear, unused codes and items answered without a walk go
// straight from idle to the done state.
// Reset clears count, total and control; the width memory is not cleared (no pass).
// A stalled result holds in the output register; a new item is taken meanwhile, and
// its result waits in the done state until the output register is free.
module cell_width_prefix_table_top #(
   parameter int CAPACITY   = 1024,
   parameter int WIDTH_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // func[2:0], index[13:3], position[39:14], new_width[55:40]
   input  logic [cwpt_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[1:0], index_out[12:2], left_edge[38:13], width_out[54:39],
   // cell_count[65:55], total_width[91:66], zeros above
   output logic [cwpt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import cwpt_pkg::*;

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int TOT_W = WIDTH_BITS + CNT_W;
   localparam int ICW   = CNT_W + 11;
   localparam int PCW   = TOT_W + 26;
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

   // input fields
   logic [2:0]            req_func;
   logic [10:0]           req_index;
   logic [25:0]           req_position;
   logic [15:0]           req_new_width;
   logic [WIDTH_BITS+15:0] nw_pad;
   logic [WIDTH_BITS-1:0] req_w;

   assign req_func      = req_tdata[2:0];
   assign req_index     = req_tdata[13:3];
   assign req_position  = req_tdata[39:14];
   assign req_new_width = req_tdata[55:40];
   assign nw_pad        = {{WIDTH_BITS{1'b0}}, req_new_width};
   assign req_w         = nw_pad[WIDTH_BITS-1:0];

   // state
   cwpt_state_type        state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [TOT_W-1:0]      tot_ff, tot_in;
   logic [2:0]            op_ff, op_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [25:0]           pos_ff, pos_in;
   logic [WIDTH_BITS-1:0] w_ff, w_in;
   logic [1:0]            stat_ff, stat_in;
   logic [CNT_W-1:0]      iout_ff, iout_in;
   logic [TOT_W-1:0]      left_ff, left_in;
   logic [WIDTH_BITS-1:0] wout_ff, wout_in;
   logic [TOT_W-1:0]      acc_ff, acc_in;
   logic                  found_ff, found_in;
   logic                  down_ff, down_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      lim_ff, lim_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0]      rd_addr_ff, rd_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memory port
   logic                  ram_we;
   logic [CNT_W-1:0]      ram_wa;
   logic [WIDTH_BITS-1:0] ram_wd;
   logic [CNT_W-1:0]      ram_ra;
   logic [WIDTH_BITS-1:0] ram_rd;

   // comparison helpers
   logic [ICW-1:0]        idx_e, cnt_e;
   logic [PCW-1:0]        pos_e, tot_e, pos_ff_e, sum_e;
   logic                  issue;
   logic [TOT_W-1:0]      sum;
   logic                  req_fire;

   // result field padding
   logic [CNT_W+10:0]     iout_pad, cnt_pad;
   logic [TOT_W+25:0]     left_pad, tot_pad;
   logic [WIDTH_BITS+15:0] wout_pad;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign idx_e    = {{CNT_W{1'b0}}, req_index};
   assign cnt_e    = {11'd0, cnt_ff};
   assign pos_e    = {{TOT_W{1'b0}}, req_position};
   assign tot_e    = {26'd0, tot_ff};
   assign pos_ff_e = {{TOT_W{1'b0}}, pos_ff};

   // shared adder: running edge plus the width just read
   assign sum   = acc_ff + TOT_W'(ram_rd);
   assign sum_e = {26'd0, sum};

   // walk pointer: up reads ptr while ptr < lim, down reads ptr-1 while ptr > lim
   assign issue  = down_ff ? (ptr_ff > lim_ff) : (ptr_ff < lim_ff);
   assign ram_ra = down_ff ? (ptr_ff - CNT_ONE) : ptr_ff;

   cwpt_width_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW),
      .DW    (WIDTH_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa[AW-1:0]),
      .wr_data (ram_wd),
      .rd_addr (ram_ra[AW-1:0]),
      .rd_data (ram_rd)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      tot_in       = tot_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      w_in         = w_ff;
      stat_in      = stat_ff;
      iout_in      = iout_ff;
      left_in      = left_ff;
      wout_in      = wout_ff;
      acc_in       = acc_ff;
      found_in     = found_ff;
      down_in      = down_ff;
      ptr_in       = ptr_ff;
      lim_in       = lim_ff;
      rd_pend_in   = 1'b0;
      rd_addr_in   = ram_ra;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_wa       = idx_ff;
      ram_wd       = w_ff;
      iout_pad     = '0;
      cnt_pad      = '0;
      left_pad     = '0;
      tot_pad      = '0;
      wout_pad     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_func;
               idx_in   = idx_e[CNT_W-1:0];
               pos_in   = req_position;
               w_in     = req_w;
               stat_in  = STAT_OK;
               iout_in  = '0;
               left_in  = '0;
               wout_in  = '0;
               acc_in   = '0;
               found_in = 1'b0;
               down_in  = 1'b0;
               ptr_in   = '0;
               lim_in   = '0;
               state_in = ST_DONE;
               unique case (req_func)
                  FUNC_INSERT: begin
                     if (idx_e > cnt_e) begin
                        stat_in = STAT_BAD_IDX;
                     end else if (cnt_ff == CNT_CAP) begin
                        stat_in = STAT_FULL;
                     end else begin
                        down_in  = 1'b1;
                        ptr_in   = cnt_ff;
                        lim_in   = idx_e[CNT_W-1:0];
                        state_in = ST_WALK;
                     end
                  end
                  FUNC_ERASE: begin
                     if (idx_e >= cnt_e) begin
                        stat_in = STAT_BAD_IDX;
                     end else begin
                        ptr_in   = idx_e[CNT_W-1:0];
                        lim_in   = cnt_ff;
                        state_in = ST_WALK;
                     end
                  end
                  FUNC_SET: begin
                     if (idx_e >= cnt_e) begin
                        stat_in = STAT_BAD_IDX;
                     end else begin
                        ptr_in   = idx_e[CNT_W-1:0];
                        lim_in   = idx_e[CNT_W-1:0] + CNT_ONE;
                        state_in = ST_WALK;
                     end
                  end
                  FUNC_LOCATE: begin
                     if (pos_e >= tot_e) begin
                        stat_in = STAT_PAST_END;
                        iout_in = cnt_ff;
                     end else begin
                        lim_in   = cnt_ff;
                        state_in = ST_WALK;
                     end
                  end
                  FUNC_RANGE: begin
                     if (idx_e > cnt_e) begin
                        stat_in = STAT_BAD_IDX;
                     end else if (idx_e == cnt_e) begin
                        left_in = tot_ff;
                     end else begin
                        lim_in   = idx_e[CNT_W-1:0] + CNT_ONE;
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     stat_in = STAT_OK;
                  end
               endcase
            end
         end

         ST_WALK: begin
            // issue the next read
            if (issue) begin
               rd_pend_in = 1'b1;
               ptr_in     = down_ff ? (ptr_ff - CNT_ONE) : (ptr_ff + CNT_ONE);
            end
            // handle the width read in the previous cycle
            if (rd_pend_ff) begin
               unique case (op_ff)
                  FUNC_INSERT: begin
                     ram_we = 1'b1;
                     ram_wa = rd_addr_ff + CNT_ONE;
                     ram_wd = ram_rd;
                  end
                  FUNC_ERASE: begin
                     if (rd_addr_ff == idx_ff) begin
                        tot_in = tot_ff - TOT_W'(ram_rd);
                     end else begin
                        ram_we = 1'b1;
                        ram_wa = rd_addr_ff - CNT_ONE;
                        ram_wd = ram_rd;
                     end
                  end
                  FUNC_SET: begin
                     tot_in = tot_ff - TOT_W'(ram_rd) + TOT_W'(w_ff);
                     ram_we = 1'b1;
                     ram_wa = idx_ff;
                     ram_wd = w_ff;
                  end
                  FUNC_LOCATE: begin
                     // first cell whose right edge passes the position
                     if (!found_ff) begin
                        acc_in = sum;
                        if (sum_e > pos_ff_e) begin
                           found_in = 1'b1;
                           iout_in  = rd_addr_ff;
                        end
                     end
                  end
                  FUNC_RANGE: begin
                     if (rd_addr_ff == idx_ff) begin
                        left_in = acc_ff;
                        wout_in = ram_rd;
                     end else begin
                        acc_in = sum;
                     end
                  end
                  default: begin
                     ram_we = 1'b0;
                  end
               endcase
            end
            // walk finished: insert drops the new width into the gap
            if (!issue && !rd_pend_ff) begin
               if (op_ff == FUNC_INSERT) begin
                  ram_we = 1'b1;
                  ram_wa = idx_ff;
                  ram_wd = w_ff;
               end
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               priority if (op_ff == FUNC_CLEAR) begin
                  cnt_in = '0;
                  tot_in = '0;
               end else if (op_ff == FUNC_INSERT && stat_ff == STAT_OK) begin
                  cnt_in = cnt_ff + CNT_ONE;
                  tot_in = tot_ff + TOT_W'(w_ff);
               end else if (op_ff == FUNC_ERASE && stat_ff == STAT_OK) begin
                  cnt_in = cnt_ff - CNT_ONE;
               end else begin
                  cnt_in = cnt_ff;
               end
               iout_pad    = {11'd0, iout_ff};
               cnt_pad     = {11'd0, cnt_in};
               left_pad    = {26'd0, left_ff};
               tot_pad     = {26'd0, tot_in};
               wout_pad    = {16'd0, wout_ff};
               rsp_data_in = {4'd0, tot_pad[25:0], cnt_pad[10:0], wout_pad[15:0],
                              left_pad[25:0], iout_pad[10:0], stat_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tot_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tot_ff       <= tot_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      w_ff        <= w_in;
      stat_ff     <= stat_in;
      iout_ff     <= iout_in;
      left_ff     <= left_in;
      wout_ff     <= wout_in;
      acc_ff      <= acc_in;
      found_ff    <= found_in;
      down_ff     <= down_in;
      ptr_ff      <= ptr_in;
      lim_ff      <= lim_in;
      rd_addr_ff  <= rd_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // count never passes the table size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_CAP)
      else $error("cell count above capacity");

   // a memory read returns only into the walk that issued it
   a_read_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(state_ff == ST_WALK))
      else $error("read pending outside a walk");

   // an accepted item closes the input until its result is built
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("second item taken while busy");

   // table only changes while an item is in progress
   a_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(cnt_ff) && $stable(tot_ff))
      else $error("table changed while idle");

endmodule

// ===== test/cell_width_prefix_table_top_tb.sv =====
// Self-checking testbench for the cell width prefix table: directed table and random ops.
module cell_width_prefix_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cwpt_pkg::*;

   localparam int CAPACITY = 1024;

   // Codes the block must ignore
   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;

   // Directed rows: typed expectation or predictor
   localparam bit TYPED = 1'b1;
   localparam bit PRED  = 1'b0;

   // Operation item, func in the lowest bits
   typedef struct packed {
      logic [15:0] new_width;
      logic [25:0] position;
      logic [10:0] index;
      logic [2:0]  func;
   } cell_op_type;

   // Result item, status in the lowest bits
   typedef struct packed {
      logic [25:0] total_width;
      logic [10:0] cell_count;
      logic [15:0] width_out;
      logic [25:0] left_edge;
      logic [10:0] index_out;
      logic [1:0]  status;
   } cell_result_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [10:0] index;
      logic [25:0] position;
      logic [15:0] new_width;
      bit          typed;
      logic [1:0]  status;
      logic [10:0] index_out;
      logic [25:0] left_edge;
      logic [15:0] width_out;
      logic [10:0] cell_count;
      logic [25:0] total_width;
   } op_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;

   // Shadow copy of the table
   logic [15:0]     shadow_widths [CAPACITY];
   int unsigned     shadow_count = 0;
   longint unsigned shadow_total = 0;

   cell_result_type awaited_results [$];
   int unsigned     error_count = 0;
   int unsigned     items_sent = 0;
   int unsigned     results_seen = 0;
   int unsigned     full_rejects = 0;
   int unsigned     peak_count = 0;
   bit              sender_calm = 1'b0;
   bit              receiver_calm = 1'b0;

   // Directed stimulus; typed rows carry the obvious answers
   op_row_type op_rows [25] = '{
      // empty table after reset
      '{FUNC_LOCATE, 0, 0, 0, TYPED, STAT_PAST_END, 0, 0, 0, 0, 0},
      '{FUNC_RANGE, 0, 0, 0, TYPED, STAT_OK, 0, 0, 0, 0, 0},
      '{FUNC_RANGE, 1, 0, 0, TYPED, STAT_BAD_IDX, 0, 0, 0, 0, 0},
      '{FUNC_ERASE, 0, 0, 0, TYPED, STAT_BAD_IDX, 0, 0, 0, 0, 0},
      '{FUNC_SET, 0, 0, 65535, TYPED, STAT_BAD_IDX, 0, 0, 0, 0, 0},
      '{FUNC_INSERT, 2047, 0, 5, TYPED, STAT_BAD_IDX, 0, 0, 0, 0, 0},
      // build [0, 0, 65535, 1]
      '{FUNC_INSERT, 0, 0, 65535, TYPED, STAT_OK, 0, 0, 0, 1, 65535},
      '{FUNC_INSERT, 0, 0, 0, TYPED, STAT_OK, 0, 0, 0, 2, 65535},
      '{FUNC_INSERT, 2, 0, 1, TYPED, STAT_OK, 0, 0, 0, 3, 65536},
      '{FUNC_INSERT, 1, 0, 0, TYPED, STAT_OK, 0, 0, 0, 4, 65536},
      // zero-width cells share an edge
      '{FUNC_LOCATE, 0, 0, 0, PRED, 0, 0, 0, 0, 0, 0},
      '{FUNC_LOCATE, 0, 65534, 0, PRED, 0, 0, 0, 0, 0, 0},
      '{FUNC_LOCATE, 0, 65535, 0, PRED, 0, 0, 0, 0, 0, 0},
      '{FUNC_LOCATE, 0, 65536, 0, TYPED, STAT_PAST_END, 4, 0, 0, 4, 65536},
      '{FUNC_LOCATE, 0, 26'h3FFFFFF, 0, TYPED, STAT_PAST_END, 4, 0, 0, 4, 65536},
      // range at the end, last cell, beyond
      '{FUNC_RANGE, 4, 0, 0, PRED, 0, 0, 0, 0, 0, 0},
      '{FUNC_RANGE, 3, 0, 0, PRED, 0, 0, 0, 0, 0, 0},
      '{FUNC_RANGE, 5, 0, 0, TYPED, STAT_BAD_IDX, 0, 0, 0, 4, 65536},
      '{FUNC_SET, 2, 0, 12345, PRED, 0, 0, 0, 0, 0, 0},
      '{FUNC_ERASE, 0, 0, 0, PRED, 0, 0, 0, 0, 0, 0},
      '{FUNC_ERASE, 3, 0, 0, PRED, 0, 0, 0, 0, 0, 0},
      // spare codes leave everything alone
      '{FUNC_SPARE_A, 2047, 26'h3FFFFFF, 65535, PRED, 0, 0, 0, 0, 0, 0},
      '{FUNC_SPARE_B, 0, 0, 0, PRED, 0, 0, 0, 0, 0, 0},
      '{FUNC_CLEAR, 2047, 26'h3FFFFFF, 65535, TYPED, STAT_OK, 0, 0, 0, 0, 0},
      '{FUNC_LOCATE, 0, 0, 0, TYPED, STAT_PAST_END, 0, 0, 0, 0, 0}
   };

   cell_width_prefix_table_top #(
      .CAPACITY   (CAPACITY),
      .WIDTH_BITS (16)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Applies one operation to the shadow table and returns its result
   function automatic cell_result_type apply_cell_op(cell_op_type op);
      cell_result_type res;
      longint unsigned edge_acc;
      int unsigned     k;
      int unsigned     found;
      int unsigned     n;
      res = '0;
      n = shadow_count;
      case (op.func)
         FUNC_INSERT: begin
            if (op.index > n) begin
               res.status = STAT_BAD_IDX;
            end else if (n >= CAPACITY) begin
               res.status = STAT_FULL;
               full_rejects++;
            end else begin
               for (k = n; k > op.index; k--) shadow_widths[k] = shadow_widths[k-1];
               shadow_widths[op.index] = op.new_width;
               shadow_count = n + 1;
               shadow_total += op.new_width;
            end
         end
         FUNC_ERASE: begin
            if (op.index >= n) begin
               res.status = STAT_BAD_IDX;
            end else begin
               shadow_total -= shadow_widths[op.index];
               for (k = op.index; k + 1 < n; k++) shadow_widths[k] = shadow_widths[k+1];
               shadow_count = n - 1;
            end
         end
         FUNC_SET: begin
            if (op.index >= n) begin
               res.status = STAT_BAD_IDX;
            end else begin
               shadow_total -= shadow_widths[op.index];
               shadow_widths[op.index] = op.new_width;
               shadow_total += op.new_width;
            end
         end
         FUNC_LOCATE: begin
            if (op.position >= shadow_total) begin
               res.status = STAT_PAST_END;
               res.index_out = 11'(n);
            end else begin
               // last cell whose left edge is at or below the position
               edge_acc = 0;
               found = 0;
               for (k = 0; k < n; k++) begin
                  if (edge_acc > op.position) break;
                  found = k;
                  edge_acc += shadow_widths[k];
               end
               res.index_out = 11'(found);
            end
         end
         FUNC_RANGE: begin
            if (op.index > n) begin
               res.status = STAT_BAD_IDX;
            end else if (op.index == n) begin
               res.left_edge = 26'(shadow_total);
            end else begin
               edge_acc = 0;
               for (k = 0; k < op.index; k++) edge_acc += shadow_widths[k];
               res.left_edge = 26'(edge_acc);
               res.width_out = shadow_widths[op.index];
            end
         end
         FUNC_CLEAR: begin
            shadow_count = 0;
            shadow_total = 0;
         end
         default: ;
      endcase
      res.cell_count = 11'(shadow_count);
      res.total_width = 26'(shadow_total);
      if (shadow_count > peak_count) peak_count = shadow_count;
      return res;
   endfunction

   // Idle cycles before one item, with occasional stretches of none
   function automatic int pick_gap(inout bit calm);
      if ($urandom_range(0, 31) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   // Width mix: zero, full scale, small and anything
   function automatic logic [15:0] random_width();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return 16'd0;
      if (r < 25) return 16'hFFFF;
      if (r < 45) return 16'($urandom_range(1, 15));
      return 16'($urandom);
   endfunction

   // Random operation, mostly well-formed against the current table
   function automatic cell_op_type random_op();
      cell_op_type op;
      int unsigned r;
      int          hi;
      op.func = 3'($urandom);
      op.index = 11'($urandom);
      op.position = 26'($urandom);
      op.new_width = random_width();
      r = $urandom_range(0, 99);
      if (r < 35) op.func = FUNC_INSERT;
      else if (r < 50) op.func = FUNC_ERASE;
      else if (r < 60) op.func = FUNC_SET;
      else if (r < 78) op.func = FUNC_LOCATE;
      else if (r < 95) op.func = FUNC_RANGE;
      else if (r < 97) op.func = FUNC_CLEAR;
      else op.func = ($urandom_range(0, 1) != 0) ? FUNC_SPARE_A : FUNC_SPARE_B;
      hi = (op.func == FUNC_INSERT || op.func == FUNC_RANGE) ? int'(shadow_count)
                                                             : int'(shadow_count) - 1;
      if (hi >= 0 && $urandom_range(0, 99) < 85) op.index = 11'($urandom_range(0, hi));
      if (op.func == FUNC_LOCATE) begin
         r = $urandom_range(0, 99);
         if (r < 75 && shadow_total > 0)
            op.position = 26'($urandom_range(0, 32'(shadow_total - 1)));
         else if (r < 85)
            op.position = 26'(shadow_total + $urandom_range(0, 3));
      end
      return op;
   endfunction

   // Drives one item, waits for acceptance and records what should come back
   task automatic send_op(input cell_op_type op, input bit typed,
                          input cell_result_type typed_res);
      int              gap;
      cell_result_type predicted;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= op;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_cell_op(op);
      if (typed) predicted = typed_res;
      awaited_results = {awaited_results, predicted};
      items_sent++;
   endtask

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Result side back-pressure
   initial begin : rsp_stall
      int stall;
      forever begin
         stall = pick_gap(receiver_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Compare each accepted result with the oldest awaited one
   always @(posedge clock) begin : rsp_check
      cell_result_type got;
      cell_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[91:0];
         results_seen++;
         if (awaited_results.size() == 0) begin
            $error("result item with no operation awaiting it");
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("status", 64'(want.status), 64'(got.status));
            check_field("index_out", 64'(want.index_out), 64'(got.index_out));
            check_field("left_edge", 64'(want.left_edge), 64'(got.left_edge));
            check_field("width_out", 64'(want.width_out), 64'(got.width_out));
            check_field("cell_count", 64'(want.cell_count), 64'(got.cell_count));
            check_field("total_width", 64'(want.total_width), 64'(got.total_width));
         end
      end
   end

   // Stimulus sequence
   initial begin : stimulus
      cell_op_type     op;
      cell_result_type typed_res;
      int              i;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (i = 0; i < 25; i++) begin
         op = '{op_rows[i].new_width, op_rows[i].position, op_rows[i].index, op_rows[i].func};
         typed_res = '{op_rows[i].total_width, op_rows[i].cell_count, op_rows[i].width_out,
                       op_rows[i].left_edge, op_rows[i].index_out, op_rows[i].status};
         send_op(op, op_rows[i].typed, typed_res);
      end

      // general random traffic on a modest table
      repeat (440) send_op(random_op(), PRED, '0);

      // empty it and carry on
      op = '0;
      op.func = FUNC_CLEAR;
      send_op(op, PRED, '0);
      repeat (110) send_op(random_op(), PRED, '0);
      req_tvalid <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("Ran %0d operation items, %0d results compared; table peaked at %0d cells",
               items_sent, results_seen, peak_count);
      $display("Full-table rejections seen: %0d", full_rejects);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #100ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
